FILE: hw/rtl/r256_pkg.sv
package r256_pkg;

  typedef logic [255:0] blk_t;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_BASE0 = 3'd4;
  localparam logic [2:0] CFG_BASE1 = 3'd5;
  localparam logic [2:0] CFG_BASE2 = 3'd6;
  localparam logic [2:0] CFG_BASE3 = 3'd7;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of a block sits at bits [8i+7:8i]; row r column c is byte 4c+r
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    int   src;
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + ((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 3 : 4)) % 8) + r;
        t[8*(4*c+r) +: 8] = SBOX[s[8*src +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t       t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 8; c++) begin
      a0 = s[8*(4*c)   +: 8];
      a1 = s[8*(4*c+1) +: 8];
      a2 = s[8*(4*c+2) +: 8];
      a3 = s[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

FILE: hw/rtl/r256_key_cell.sv
// one key schedule step: 8 new 32-bit words from the previous 8
module r256_key_cell import r256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  blk_t       key_prev,
  input  logic [7:0] rcon_prev,
  output blk_t       key_r,
  output logic [7:0] rcon_r
);

  blk_t        key_nxt;
  logic [31:0] w [8];
  logic [31:0] t;

  always_comb begin
    t = key_prev[255:224];
    t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rcon_prev};
    w[0] = key_prev[31:0] ^ t;
    for (int i = 1; i < 8; i++) begin
      if (i == 4) w[i] = key_prev[32*i +: 32] ^ sub_word(w[i-1]);
      else        w[i] = key_prev[32*i +: 32] ^ w[i-1];
    end
    for (int i = 0; i < 8; i++) key_nxt[32*i +: 32] = w[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcon_r <= 8'h00;
    end else if (load) begin
      key_r  <= key_nxt;
      rcon_r <= xtime(rcon_prev);
    end
  end

endmodule

FILE: hw/rtl/r256_round_cell.sv
// one cipher round stage holding one block in flight
module r256_round_cell import r256_pkg::*; #(
  parameter bit LAST = 1'b0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic vld_in,
  input  blk_t blk_in,
  input  blk_t rkey,
  output logic vld_r,
  output blk_t blk_r
);

  blk_t blk_nxt;
  blk_t ss;

  always_comb begin
    ss = sub_shift(blk_in);
    blk_nxt = (LAST ? ss : mix_columns(ss)) ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) blk_r <= blk_nxt;
  end

endmodule

FILE: hw/rtl/rijndael256_ctr_nocarry_encrypt.sv
// channel | ports                              | direction
// in      | in_valid, in_stall, in_block_offset | counter offset in
// out     | out_valid, out_stall, out_cipher_*  | ciphertext out
// cfg     | cfg_we, cfg_index, cfg_data         | key and base counter writes
//
// stage 0 adds offset and whitening key; ROUND_COUNT round cells follow, each a
// registered stage; while not stalled, transactions leave in order, one per cycle
// round keys sit in a chain of ROUND_COUNT key cells that reload every cycle; round
// key i follows a key write through cells 1 to i, never behind a later transaction
// synchronous active-low reset clears valids and reloads the all-zero key
// out_stall freezes all but key cells; in_stall is out_stall with a full chain end
module rijndael256_ctr_nocarry_encrypt import r256_pkg::*; #(
  parameter int ROUND_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_word0,
  output logic [63:0] out_cipher_word1,
  output logic [63:0] out_cipher_word2,
  output logic [63:0] out_cipher_word3,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  blk_t key_r, base_r;
  blk_t rk   [ROUND_COUNT+1];
  logic [7:0] rc [ROUND_COUNT+1];
  blk_t sblk [ROUND_COUNT+1];
  logic vld  [ROUND_COUNT+1];
  logic adv;
  logic s0_vld_r;
  blk_t s0_blk_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:  key_r[63:0]     <= cfg_data;
        CFG_KEY1:  key_r[127:64]   <= cfg_data;
        CFG_KEY2:  key_r[191:128]  <= cfg_data;
        CFG_KEY3:  key_r[255:192]  <= cfg_data;
        CFG_BASE0: base_r[63:0]    <= cfg_data;
        CFG_BASE1: base_r[127:64]  <= cfg_data;
        CFG_BASE2: base_r[191:128] <= cfg_data;
        CFG_BASE3: base_r[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  // key chain: each cell derives the next round key; cell i feeds round i
  // layout: rk[0] is the key itself, rk[i] the i-th 256-bit round key
  assign rk[0] = key_r;
  assign rc[0] = 8'h01;

  // one 256-bit schedule step yields one round key (Nb = Nk = 8)
  for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_key
    r256_key_cell u_key (
      .clk(clk), .rst_n(rst_n), .load(1'b1),
      .key_prev(rk[i-1]), .rcon_prev(rc[i-1]),
      .key_r(rk[i]), .rcon_r(rc[i])
    );
  end

  // stall stage 0 and the round cells when output is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  // counter assembly with no carry past the low word, then whitening
  always_ff @(posedge clk) begin
    if (adv) s0_blk_r <= {base_r[255:64], base_r[63:0] + in_block_offset} ^ rk[0];
  end

  assign sblk[0] = s0_blk_r;
  assign vld[0]  = s0_vld_r;

  for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_rnd
    r256_round_cell #(.LAST(i == ROUND_COUNT)) u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(vld[i-1]), .blk_in(sblk[i-1]), .rkey(rk[i]),
      .vld_r(vld[i]), .blk_r(sblk[i])
    );
  end

  assign out_valid        = vld[ROUND_COUNT];
  assign out_cipher_word0 = sblk[ROUND_COUNT][63:0];
  assign out_cipher_word1 = sblk[ROUND_COUNT][127:64];
  assign out_cipher_word2 = sblk[ROUND_COUNT][191:128];
  assign out_cipher_word3 = sblk[ROUND_COUNT][255:192];

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import r256_pkg::*;

  localparam int ROUNDS    = 14;
  localparam int KEY_WORDS = 4 * (ROUNDS + 1) * 2; // 32-bit schedule words
  localparam int SETTLE    = 4 * (ROUNDS + 2);
  localparam int WD_LIMIT  = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_block_offset;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_cipher_word0;
  logic [63:0] out_cipher_word1;
  logic [63:0] out_cipher_word2;
  logic [63:0] out_cipher_word3;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  rijndael256_ctr_nocarry_encrypt #(.ROUND_COUNT(ROUNDS)) DUT (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state: key and base counter registers plus expanded schedule
  logic [63:0]  key_reg [4];
  logic [63:0]  base_reg [4];
  logic [255:0] sched_key [ROUNDS + 1];

  blk_t cipher_q [$];
  int   err_count;
  int   idle_pct_in;
  int   idle_pct_out;
  int   quiet_cycles;

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // standard Rijndael schedule with Nk = Nb = 8, byte-wise little-endian
  task automatic rebuild_schedule();
    logic [31:0] w [KEY_WORDS];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_reg[i / 2][32 * (i % 2) +: 32];
    for (int i = 8; i < KEY_WORDS; i++) begin
      t = w[i - 1];
      if (i % 8 == 0) begin
        t = {SBOX[t[7:0]], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]] ^ rc};
        rc = gmul2(rc);
      end else if (i % 8 == 4) begin
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      end
      w[i] = w[i - 8] ^ t;
    end
    for (int r = 0; r <= ROUNDS; r++)
      for (int k = 0; k < 8; k++) sched_key[r][32 * k +: 32] = w[8 * r + k];
  endtask

  function automatic blk_t byte_sub_rotate(input blk_t s);
    blk_t t;
    int   sh [4];
    sh = '{0, 1, 3, 4};
    for (int c = 0; c < 8; c++)
      for (int r = 0; r < 4; r++)
        t[8 * (4 * c + r) +: 8] = SBOX[s[8 * (4 * ((c + sh[r]) % 8) + r) +: 8]];
    return t;
  endfunction

  function automatic blk_t column_mix(input blk_t s);
    blk_t       t;
    logic [7:0] a [4];
    logic [7:0] x;
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[8 * (4 * c + r) +: 8];
      x = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int r = 0; r < 4; r++)
        t[8 * (4 * c + r) +: 8] = a[r] ^ x ^ gmul2(a[r] ^ a[(r + 1) % 4]);
    end
    return t;
  endfunction

  function automatic blk_t keystream_block(input logic [63:0] offset);
    blk_t s;
    s = {base_reg[3], base_reg[2], base_reg[1], base_reg[0] + offset};
    s ^= sched_key[0];
    for (int r = 1; r < ROUNDS; r++) s = column_mix(byte_sub_rotate(s)) ^ sched_key[r];
    return byte_sub_rotate(s) ^ sched_key[ROUNDS];
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    err_count++;
  endtask

  // register write, block idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_KEY3) begin
      key_reg[idx[1:0]] = val;
      rebuild_schedule();
    end else begin
      base_reg[idx[1:0]] = val;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // one transaction on the input channel; valid stays up until the next idle
  task automatic send_offset(input logic [63:0] offset);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_block_offset <= offset;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_q.push_back(keystream_block(offset));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result checker
  always @(posedge clk) begin
    blk_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report("unexpected transaction", out_cipher_word0, '0);
      end else begin
        want = cipher_q.pop_front();
        if (out_cipher_word0 !== want[63:0])    report("word0", out_cipher_word0, want[63:0]);
        if (out_cipher_word1 !== want[127:64])  report("word1", out_cipher_word1, want[127:64]);
        if (out_cipher_word2 !== want[191:128]) report("word2", out_cipher_word2, want[191:128]);
        if (out_cipher_word3 !== want[255:192]) report("word3", out_cipher_word3, want[255:192]);
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct_out);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("rijndael256_ctr_nocarry_encrypt: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // zero key, zero counter, the extreme offsets, a single-bit and alternating patterns
  task automatic test_reset_defaults();
    send_offset('0);
    send_offset('1);
    send_offset({64{1'b1}});
    send_offset(64'h8000_0000_0000_0000);
    send_offset(64'h5555_5555_5555_5555);
    send_offset(64'haaaa_aaaa_aaaa_aaaa);
    drain();
  endtask

  // low word wrap with no carry into word 1
  task automatic test_offset_wrap();
    write_reg(CFG_BASE0, 64'hffff_ffff_ffff_fff0);
    write_reg(CFG_BASE1, 64'h0123_4567_89ab_cdef);
    for (int i = 14; i < 20; i++) send_offset(64'(i));
    send_offset({64{1'b1}});
    drain();
  endtask

  // all-ones key and counter, then every register with random values
  task automatic test_register_extremes();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], {64{1'b1}});
    send_offset('0);
    send_offset({64{1'b1}});
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], rand64());
    send_offset('0);
    send_offset(rand64());
    drain();
  endtask

  // random offsets under several key and counter settings
  task automatic test_random_stream(input int n);
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 8; i++)
        if ($urandom_range(1)) write_reg(i[2:0], (p == 0) ? '0 : rand64());
      // phase 1: back-to-back, no idling on either side
      idle_pct_in  = (p == 1) ? 0 : 10;
      idle_pct_out = (p == 1) ? 0 : 10;
      for (int i = 0; i < n / 4; i++) begin
        case ($urandom_range(3))
          0:       send_offset(64'($urandom_range(255)));
          1:       send_offset({64{1'b1}} - 64'($urandom_range(255)));
          default: send_offset(rand64());
        endcase
        // hold off until the pipe is empty once per phase
        if (i == n / 8) begin
          in_valid <= 1'b0;
          while (cipher_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    idle_pct_in  = 10;
    idle_pct_out = 10;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_block_offset = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_KEY0;
    cfg_data        = '0;
    out_stall       = 1'b0;
    err_count       = 0;
    quiet_cycles    = 0;
    idle_pct_in     = 10;
    idle_pct_out    = 10;
    for (int i = 0; i < 4; i++) begin
      key_reg[i]  = '0;
      base_reg[i] = '0;
    end
    rebuild_schedule();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    test_reset_defaults();
    test_offset_wrap();
    test_register_extremes();
    test_random_stream(1000);

    if (err_count == 0 && cipher_q.size() == 0)
      $display("rijndael256_ctr_nocarry_encrypt: match");
    else
      $display("rijndael256_ctr_nocarry_encrypt: mismatch");
    $finish;
  end

endmodule

FILE: rijndael256_ctr_nocarry_encrypt.f
hw/rtl/r256_pkg.sv
hw/rtl/r256_key_cell.sv
hw/rtl/r256_round_cell.sv
hw/rtl/rijndael256_ctr_nocarry_encrypt.sv
verif/testbench.sv
